// ===== sv/hsv2rgb_pkg.sv =====
// ============================================================================
// hsv2rgb_pkg - shared constants and helpers for the HSV to RGB converter
// Holds the field widths, the pipeline depth and the hue weighting function.
// ============================================================================
package hsv2rgb_pkg;

    // Default width of the saturation, value and color levels
    localparam int CHANNEL_BITS_DEF = 8;

    // Hue field: whole degrees, one full turn
    localparam int HUE_BITS   = 9;
    localparam int HUE_TURN   = 360;
    localparam int SECTOR_DEG = 60;

    // Hue weight k runs 0..60
    localparam int K_BITS = 6;

    // Red, green and blue lanes
    localparam int NUM_LANES = 3;

    // Register stages from input item to output register
    localparam int PIPE_STAGES = 8;

    // Phase offset of a lane in degrees: red 300, green 180, blue 60
    function automatic logic [HUE_BITS-1:0] lane_offset(input int lane);
        return HUE_BITS'(SECTOR_DEG * (5 - 2 * lane));
    endfunction

    // Reduce an angle of 0..511 degrees to 0..359
    function automatic logic [HUE_BITS-1:0] hue_wrap(input logic [HUE_BITS-1:0] hue);
        logic [HUE_BITS-1:0] res;
        res = hue;
        if (hue >= HUE_BITS'(HUE_TURN)) begin
            res = hue - HUE_BITS'(HUE_TURN);
        end
        return res;
    endfunction

    // Weight k = clamp(min(p, 240 - p), 0, 60) with p = (offset + hue) mod 360
    function automatic logic [K_BITS-1:0] hue_weight(
        input logic [HUE_BITS-1:0] hue,
        input logic [HUE_BITS-1:0] offset
    );
        logic [HUE_BITS:0] p;
        logic [K_BITS-1:0] k;
        p = {1'b0, hue} + {1'b0, offset};
        if (p >= (HUE_BITS+1)'(HUE_TURN)) begin
            p = p - (HUE_BITS+1)'(HUE_TURN);
        end
        if (p <= (HUE_BITS+1)'(SECTOR_DEG)) begin
            k = p[K_BITS-1:0];
        end else if (p <= (HUE_BITS+1)'(3 * SECTOR_DEG)) begin
            k = K_BITS'(SECTOR_DEG);
        end else if (p < (HUE_BITS+1)'(4 * SECTOR_DEG)) begin
            k = K_BITS'((HUE_BITS+1)'(4 * SECTOR_DEG) - p);
        end else begin
            k = '0;
        end
        return k;
    endfunction

endpackage

// ===== sv/hsv_to_rgb_converter_core.sv =====
// Throughput: one item per cycle while the output is not stalled; every stage
// holds one item, and the datapath has eight stages (hue weight, multiply,
// divide by full scale, divide by 60).
// A stalled output lets earlier stages keep filling until the pipe is full.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
// ============================================================================
// hsv_to_rgb_converter_core - streaming HSV to RGB converter
// Per lane: level = floor(V * (60*FULL - S*k) / (60*FULL)), k from the hue.
// ============================================================================
module hsv_to_rgb_converter_core #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata: hue_degrees, saturation_level, brightness_level (low bit up), zero pad
    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    input  logic [((hsv2rgb_pkg::HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    // m_tdata: red_level, green_level, blue_level (low bit up), zero pad
    output logic                                                   m_tvalid,
    input  logic                                                   m_tready,
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                    m_tdata
);
    import hsv2rgb_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int FULL   = 2**CB - 1;
    localparam int OUT_W  = ((3*CB+7)/8)*8;
    localparam int DW     = CB + 6;          // 60*FULL - S*k
    localparam int NW     = 2*CB + 6;        // V * diff
    localparam int QW     = CB + 6;          // quotient by FULL, at most 60*FULL
    localparam int XW     = QW - 2;          // quotient by 4
    localparam int SH     = XW + 4;          // reciprocal shift for divide by 15
    localparam int MW     = SH - 3;
    localparam int PW     = XW + MW;
    localparam int RECIP  = (2**SH + 14) / 15;

    localparam logic [DW-1:0] FULL_60   = DW'(60 * FULL);
    localparam logic [QW:0]   FULL_WIDE = (QW+1)'(FULL);
    localparam logic [MW-1:0] RECIP_C   = MW'(RECIP);

    // Stage handshake
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES:0]   stage_en;
    logic [PIPE_STAGES-1:0] valid_in;

    assign stage_en[PIPE_STAGES] = m_tready;

    // Each stage takes the valid bit of the one before it
    assign valid_in = {valid_reg[PIPE_STAGES-2:0], s_tvalid};

    genvar g;
    generate
        for (g = 0; g < PIPE_STAGES; g++) begin : g_ctrl
            // Advance a stage when it is empty or its successor advances
            assign stage_en[g]   = !valid_reg[g] || stage_en[g+1];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (stage_en[g]) begin
                    valid_reg[g] <= valid_in[g];
                end
            end
        end
    endgenerate

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    // Stage 1: unpack and wrap the hue
    logic [HUE_BITS-1:0] hue1_reg;
    logic [CB-1:0]       sat1_reg, val1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            hue1_reg <= hue_wrap(s_tdata[HUE_BITS-1:0]);
            sat1_reg <= s_tdata[HUE_BITS+CB-1:HUE_BITS];
            val1_reg <= s_tdata[HUE_BITS+2*CB-1:HUE_BITS+CB];
        end
    end

    // Shared per-item payload for stages 2 and 3
    logic [CB-1:0] sat2_reg, val2_reg, val3_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
        if (stage_en[2]) begin
            val3_reg <= val2_reg;
        end
    end

    logic [CB-1:0] level [NUM_LANES];

    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            logic [K_BITS-1:0] k2_reg;
            logic [DW-1:0]     diff3_reg;
            logic [NW-1:0]     num4_reg;
            logic [QW-1:0]     a5_reg;
            logic [QW:0]       t5_reg;
            logic [QW-1:0]     q6_reg;
            logic [PW-1:0]     prod7_reg;
            logic [CB-1:0]     level8_reg;

            logic [QW:0]   a_fold2, t_fold2, a_fold3, t_fold3, q_sum;
            logic [QW-1:0] q6_next;

            // Fold twice more and fix the last remainder to finish divide by FULL
            always_comb begin
                a_fold2 = (QW+1)'(t5_reg >> CB);
                t_fold2 = a_fold2 + (QW+1)'(t5_reg[CB-1:0]);
                a_fold3 = (QW+1)'(t_fold2 >> CB);
                t_fold3 = a_fold3 + (QW+1)'(t_fold2[CB-1:0]);
                q_sum   = {1'b0, a5_reg} + a_fold2 + a_fold3
                        + (QW+1)'(t_fold3 >= FULL_WIDE);
                q6_next = q_sum[QW-1:0];
            end

            always_ff @(posedge aclk) begin
                // Stage 2: hue weight of this lane
                if (stage_en[1]) begin
                    k2_reg <= hue_weight(hue1_reg, lane_offset(g));
                end
                // Stage 3: scaled saturation loss
                if (stage_en[2]) begin
                    diff3_reg <= FULL_60 - DW'(DW'(sat2_reg) * DW'(k2_reg));
                end
                // Stage 4: multiply by value
                if (stage_en[3]) begin
                    num4_reg <= NW'(val3_reg) * NW'(diff3_reg);
                end
                // Stage 5: first fold of divide by 2^CB - 1
                if (stage_en[4]) begin
                    a5_reg <= num4_reg[NW-1:CB];
                    t5_reg <= {1'b0, num4_reg[NW-1:CB]} + (QW+1)'(num4_reg[CB-1:0]);
                end
                // Stage 6: finish divide by FULL
                if (stage_en[5]) begin
                    q6_reg <= q6_next;
                end
                // Stage 7: drop two bits, multiply by reciprocal of 15
                if (stage_en[6]) begin
                    prod7_reg <= PW'(q6_reg[QW-1:2]) * PW'(RECIP_C);
                end
                // Stage 8: output register
                if (stage_en[7]) begin
                    level8_reg <= prod7_reg[SH+CB-1:SH];
                end
            end

            assign level[g] = level8_reg;
        end
    endgenerate

    assign m_tdata = OUT_W'({level[2], level[1], level[0]});

endmodule

// ===== sv/hsv2rgb_checker.sv =====
// ============================================================================
// hsv2rgb_checker - port-level checks for the HSV to RGB converter
// Tracks items in flight and checks reset, stall and occupancy behavior.
// ============================================================================
module hsv2rgb_checker #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input logic                                                   aclk,
    input logic                                                   aresetn,
    input logic                                                   s_tvalid,
    input logic                                                   s_tready,
    // m_tdata: red_level, green_level, blue_level (low bit up)
    input logic                                                   m_tvalid,
    input logic                                                   m_tready,
    input logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                    m_tdata
);
    import hsv2rgb_pkg::*;

    localparam int CW = $clog2(PIPE_STAGES + 2);

    logic [CW-1:0] count_reg;
    logic          in_fire, out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Count items accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_fire && !out_fire) begin
            count_reg <= count_reg + CW'(1);
        end else if (out_fire && !in_fire) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // No result without an item in flight, never more than the pipe holds
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> count_reg != '0)
        else $error("result without accepted item");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(PIPE_STAGES))
        else $error("more items in flight than stages");

    // A pipe with room takes an item
    a_room_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CW'(PIPE_STAGES) |-> s_tready)
        else $error("s_tready low with free stage");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker #(
    .CHANNEL_BITS(CHANNEL_BITS)
) u_hsv2rgb_checker (.*);
